### sv/kbc8042_pkg.sv
`default_nettype none

package kbc8042_pkg;

  // Output byte FIFO geometry.
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned SUM_W      = PTR_W + 1;
  localparam int unsigned KEY_MAX    = 4;

  // Job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Bus operation codes.
  localparam logic [2:0] OP_DATA_READ   = 3'd0;
  localparam logic [2:0] OP_DATA_WRITE  = 3'd1;
  localparam logic [2:0] OP_STATUS_READ = 3'd2;
  localparam logic [2:0] OP_CMD_WRITE   = 3'd3;
  localparam logic [2:0] OP_KEY         = 3'd4;

  // Controller commands.
  localparam logic [7:0] CMD_READ_CFG   = 8'h20;
  localparam logic [7:0] CMD_WRITE_CFG  = 8'h60;
  localparam logic [7:0] CMD_VERSION    = 8'hA1;
  localparam logic [7:0] CMD_SELF_TEST  = 8'hAA;
  localparam logic [7:0] CMD_IF_TEST    = 8'hAB;
  localparam logic [7:0] CMD_ZERO_B4    = 8'hB4;
  localparam logic [7:0] CMD_ZERO_C9    = 8'hC9;
  localparam logic [7:0] CMD_KBD_OFF    = 8'hAD;
  localparam logic [7:0] CMD_KBD_ON     = 8'hAE;
  localparam logic [7:0] CMD_READ_IN    = 8'hC0;
  localparam logic [7:0] CMD_READ_OUT   = 8'hD0;
  localparam logic [7:0] CMD_WRITE_OUT  = 8'hD1;
  localparam logic [7:0] CMD_PULSE_LOW  = 8'hF1;

  // Keyboard commands.
  localparam logic [7:0] KCMD_SET       = 8'hF0;
  localparam logic [7:0] KCMD_ENABLE    = 8'hF4;
  localparam logic [7:0] KCMD_DISABLE   = 8'hF5;
  localparam logic [7:0] KCMD_RESET     = 8'hFF;

  // Reply bytes.
  localparam logic [7:0] RPL_ACK        = 8'hFA;
  localparam logic [7:0] RPL_BAT_OK     = 8'hAA;
  localparam logic [7:0] RPL_TEST_OK    = 8'h55;
  localparam logic [7:0] RPL_VERSION    = 8'h30;
  localparam logic [7:0] RPL_SET_NUM    = 8'h02;
  localparam logic [7:0] RPL_ZERO       = 8'h00;

  // Reset values and bit positions.
  localparam logic [7:0] STATUS_RESET   = 8'h1C;
  localparam logic [7:0] CONFIG_RESET   = 8'h51;
  localparam logic [7:0] OUTPORT_RESET  = 8'hE0;
  localparam int unsigned ST_OBF        = 0;
  localparam int unsigned ST_IBF        = 1;
  localparam int unsigned ST_SYS        = 2;
  localparam int unsigned ST_CMD        = 3;
  localparam int unsigned CFG_KBD_INT   = 0;
  localparam int unsigned OUTP_OBF      = 4;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data_byte;
    logic [31:0] key_bytes;
    logic [2:0]  key_count;
  } kbc_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_raise;
    logic       irq_lower;
    logic       port_write_valid;
    logic [7:0] port_write_value;
    logic       pulse_valid;
    logic [7:0] pulse_value;
    logic       key_dropped;
  } kbc_out_t;

  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_DATA_READ,
    JOB_DATA_WRITE,
    JOB_STATUS_READ,
    JOB_CMD_WRITE,
    JOB_KEY
  } job_e;

  typedef enum logic [3:0] {
    CC_OTHER,
    CC_READ_CFG,
    CC_WRITE_CFG,
    CC_VERSION,
    CC_SELF_TEST,
    CC_REPLY_ZERO,
    CC_KBD_OFF,
    CC_KBD_ON,
    CC_READ_IN,
    CC_READ_OUT,
    CC_WRITE_OUT,
    CC_PULSE
  } ctrl_e;

  typedef enum logic [1:0] {
    KC_OTHER,
    KC_SET,
    KC_ACK_ONLY,
    KC_RESET
  } kbd_e;

  typedef struct packed {
    job_e        kind;
    ctrl_e       ctrl;
    kbd_e        kbd;
    logic [7:0]  data_byte;
    logic [31:0] key_bytes;
    logic [2:0]  key_len;
  } job_t;

endpackage

`default_nettype wire

### sv/kbc8042_front.sv
`default_nettype none

module kbc8042_front
  import kbc8042_pkg::*;
(
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire kbc_in_t in_data_i,
  output logic         job_valid_o,
  input  wire logic    job_ready_i,
  output job_t         job_o
);

  // Classify the access and the command byte so the back end only selects.
  always_comb begin
    job_o           = '0;
    job_o.data_byte = in_data_i.data_byte;
    job_o.key_bytes = in_data_i.key_bytes;
    job_o.key_len   = (in_data_i.key_count > 3'(KEY_MAX)) ? 3'(KEY_MAX)
                                                          : in_data_i.key_count;

    case (in_data_i.op)
      OP_DATA_READ:   job_o.kind = JOB_DATA_READ;
      OP_DATA_WRITE:  job_o.kind = JOB_DATA_WRITE;
      OP_STATUS_READ: job_o.kind = JOB_STATUS_READ;
      OP_CMD_WRITE:   job_o.kind = JOB_CMD_WRITE;
      OP_KEY:         job_o.kind = JOB_KEY;
      default:        job_o.kind = JOB_NONE;
    endcase

    case (in_data_i.data_byte)
      CMD_READ_CFG:  job_o.ctrl = CC_READ_CFG;
      CMD_WRITE_CFG: job_o.ctrl = CC_WRITE_CFG;
      CMD_VERSION:   job_o.ctrl = CC_VERSION;
      CMD_SELF_TEST: job_o.ctrl = CC_SELF_TEST;
      CMD_IF_TEST, CMD_ZERO_B4, CMD_ZERO_C9: job_o.ctrl = CC_REPLY_ZERO;
      CMD_KBD_OFF:   job_o.ctrl = CC_KBD_OFF;
      CMD_KBD_ON:    job_o.ctrl = CC_KBD_ON;
      CMD_READ_IN:   job_o.ctrl = CC_READ_IN;
      CMD_READ_OUT:  job_o.ctrl = CC_READ_OUT;
      CMD_WRITE_OUT: job_o.ctrl = CC_WRITE_OUT;
      default: begin
        job_o.ctrl = (in_data_i.data_byte >= CMD_PULSE_LOW) ? CC_PULSE : CC_OTHER;
      end
    endcase

    case (in_data_i.data_byte)
      KCMD_SET:                   job_o.kbd = KC_SET;
      KCMD_ENABLE, KCMD_DISABLE:  job_o.kbd = KC_ACK_ONLY;
      KCMD_RESET:                 job_o.kbd = KC_RESET;
      default:                    job_o.kbd = KC_OTHER;
    endcase
  end

  assign job_valid_o = in_valid_i;
  assign in_ready_o  = job_ready_i;

endmodule

`default_nettype wire

### sv/kbc8042_queue.sv
`default_nettype none

module kbc8042_queue
  import kbc8042_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire job_t in_job_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output job_t      out_job_o
);

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_job_o   = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_job_i;
    end
  end

endmodule

`default_nettype wire

### sv/kbc8042_back.sv
`default_nettype none

module kbc8042_back
  import kbc8042_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       job_valid_i,
  output logic            job_ready_o,
  input  wire job_t       job_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output kbc_out_t        out_data_o
);

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_CFG,
    PEND_OUT
  } pend_e;

  logic [7:0]       fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [7:0]       last_q, last_d;
  logic [7:0]       status_q, status_d;
  logic [7:0]       config_q, config_d;
  logic [7:0]       outport_q, outport_d;
  pend_e            pend_q, pend_d;
  logic             kpend_q, kpend_d;
  logic [7:0]       in_port_q;
  logic             out_vld_q;
  kbc_out_t         out_q, res;

  logic             take;
  logic [2:0]       app_n;
  logic [7:0]       app_b [KEY_MAX];
  logic [PTR_W-1:0] wr_addr [KEY_MAX];
  logic [1:0]       n_put;
  logic [7:0]       put0, put1;
  logic             put1_ok, put2_ok;
  logic [SUM_W-1:0] cnt_ext, addr_sum, cnt_sum;

  assign take        = job_valid_i && (!out_vld_q || out_ready_i);
  assign job_ready_o = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign cnt_ext = {1'b0, count_q};
  assign put1_ok = (cnt_ext + SUM_W'(1)) < SUM_W'(FIFO_DEPTH);
  assign put2_ok = (cnt_ext + SUM_W'(2)) < SUM_W'(FIFO_DEPTH);

  always_comb begin
    addr_sum = '0;
    for (int i = 0; i < KEY_MAX; i++) begin
      addr_sum = SUM_W'(head_q) + cnt_ext + SUM_W'(i);
      if (addr_sum >= SUM_W'(FIFO_DEPTH)) begin
        addr_sum = addr_sum - SUM_W'(FIFO_DEPTH);
      end
      wr_addr[i] = addr_sum[PTR_W-1:0];
    end
  end

  always_comb begin
    count_d   = count_q;
    head_d    = head_q;
    last_d    = last_q;
    status_d  = status_q;
    config_d  = config_q;
    outport_d = outport_q;
    pend_d    = pend_q;
    kpend_d   = kpend_q;
    res       = '0;
    app_n     = '0;
    n_put     = '0;
    put0      = '0;
    put1      = '0;
    cnt_sum   = '0;
    for (int i = 0; i < KEY_MAX; i++) begin
      app_b[i] = job_i.key_bytes[8*i +: 8];
    end

    case (job_i.kind)
      JOB_DATA_READ: begin
        if (count_q == '0) begin
          res.read_data = last_q;
        end else begin
          last_d        = fifo_q[head_q];
          res.read_data = fifo_q[head_q];
          head_d        = (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
          count_d       = count_q - 1'b1;
          res.irq_raise = (count_q != PTR_W'(1));
          status_d[ST_OBF]   = (count_q != PTR_W'(1));
          outport_d[OUTP_OBF] = (count_q != PTR_W'(1));
        end
      end
      JOB_STATUS_READ: begin
        res.read_data    = status_q;
        status_d[ST_IBF] = 1'b0;
      end
      JOB_KEY: begin
        if ((cnt_ext + SUM_W'(job_i.key_len)) >= SUM_W'(FIFO_DEPTH) &&
            job_i.key_len != '0) begin
          res.key_dropped = 1'b1;
        end else begin
          app_n         = job_i.key_len;
          res.irq_raise = config_q[CFG_KBD_INT];
        end
      end
      JOB_CMD_WRITE: begin
        status_d[ST_IBF] = 1'b1;
        status_d[ST_CMD] = 1'b1;
        pend_d           = PEND_NONE;
        case (job_i.ctrl)
          CC_READ_CFG: begin
            n_put = 2'd1;
            put0  = config_q;
          end
          CC_WRITE_CFG: pend_d = PEND_CFG;
          CC_VERSION: begin
            n_put = 2'd1;
            put0  = RPL_VERSION;
          end
          CC_SELF_TEST: begin
            status_d[ST_SYS] = 1'b1;
            n_put            = 2'd1;
            put0             = RPL_TEST_OK;
          end
          CC_REPLY_ZERO: begin
            n_put = 2'd1;
            put0  = RPL_ZERO;
          end
          CC_KBD_OFF: begin
            config_d[CFG_KBD_INT] = 1'b0;
            res.irq_lower         = 1'b1;
          end
          CC_KBD_ON: begin
            config_d[CFG_KBD_INT] = 1'b1;
            res.irq_raise         = (count_q != '0);
          end
          CC_READ_IN: begin
            n_put = 2'd1;
            put0  = in_port_q;
          end
          CC_READ_OUT: begin
            n_put = 2'd1;
            put0  = outport_q;
          end
          CC_WRITE_OUT: pend_d = PEND_OUT;
          CC_PULSE: begin
            res.pulse_valid = 1'b1;
            res.pulse_value = outport_q ^ {4'h0, job_i.data_byte[3:0]};
          end
          default: ;
        endcase
      end
      JOB_DATA_WRITE: begin
        status_d[ST_IBF] = 1'b1;
        status_d[ST_CMD] = 1'b0;
        if (pend_q == PEND_CFG) begin
          config_d = job_i.data_byte;
          pend_d   = PEND_NONE;
        end else if (pend_q == PEND_OUT) begin
          outport_d            = job_i.data_byte;
          res.port_write_valid = 1'b1;
          res.port_write_value = job_i.data_byte;
          pend_d               = PEND_NONE;
        end else if (kpend_q) begin
          put0    = RPL_ACK;
          put1    = RPL_SET_NUM;
          n_put   = (job_i.data_byte == '0) ? 2'd2 : 2'd1;
          kpend_d = 1'b0;
        end else begin
          case (job_i.kbd)
            KC_SET: begin
              n_put   = 2'd1;
              put0    = RPL_ACK;
              kpend_d = 1'b1;
            end
            KC_ACK_ONLY: begin
              n_put = 2'd1;
              put0  = RPL_ACK;
            end
            KC_RESET: begin
              n_put = 2'd2;
              put0  = RPL_ACK;
              put1  = RPL_BAT_OK;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // Controller and keyboard replies: each byte is dropped on its own when the FIFO is near full.
    if (n_put != '0) begin
      app_b[0] = put0;
      app_b[1] = put1;
      app_n    = {2'b00, put1_ok} + {2'b00, (n_put == 2'd2) && put2_ok};
    end

    if (app_n != '0) begin
      cnt_sum             = cnt_ext + SUM_W'(app_n);
      count_d             = cnt_sum[PTR_W-1:0];
      status_d[ST_OBF]    = 1'b1;
      outport_d[OUTP_OBF] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      head_q    <= '0;
      last_q    <= '0;
      status_q  <= STATUS_RESET;
      config_q  <= CONFIG_RESET;
      outport_q <= OUTPORT_RESET;
      pend_q    <= PEND_NONE;
      kpend_q   <= 1'b0;
      in_port_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        in_port_q <= cfg_data_i;
      end
      if (take) begin
        count_q   <= count_d;
        head_q    <= head_d;
        last_q    <= last_d;
        status_q  <= status_d;
        config_q  <= config_d;
        outport_q <= outport_d;
        pend_q    <= pend_d;
        kpend_q   <= kpend_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
      for (int i = 0; i < KEY_MAX; i++) begin
        if (3'(i) < app_n) begin
          fifo_q[wr_addr[i]] <= app_b[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/keyboard_controller_8042.sv
// Keyboard controller register block: bus accesses and key events in, one result beat out.
// An accepted beat is written into the job queue; the back end then takes it and registers its result beat.
// Throughput: one beat per cycle while the result side keeps up; the back end applies each job combinationally.
// A two-entry job queue and the output register decouple input and output stalls.
// Reset (rst_ni low, asynchronous) clears the FIFO, pending commands and the input port
// register, and loads status 0x1C, configuration 0x51 and output port 0xE0.
`default_nettype none

module keyboard_controller_8042
  import kbc8042_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write channel: the input port value.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  // Access channel.
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire kbc_in_t    in_data_i,
  // Result channel.
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output kbc_out_t        out_data_o
);

  // The front end decodes every beat into a job: the operation, the class of
  // the controller command and the class of the keyboard command the byte
  // would be. Which of those applies depends on pending-command state, and
  // that state lives only in the back end.
  logic fr_valid, fr_ready;
  job_t fr_job;

  // Queue head toward the back end.
  logic bk_valid, bk_ready;
  job_t bk_job;

  // The input port register is always writable; writes must arrive only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  kbc8042_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  // Short queue so a stalled result does not immediately back up the bus side.
  kbc8042_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_job_i    (fr_job),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_job_o   (bk_job)
  );

  // The back end holds the byte FIFO and all controller state. It retires one
  // job per cycle into its output register whenever that register is empty
  // or being drained in the same cycle.
  kbc8042_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_i (bk_valid),
    .job_ready_o (bk_ready),
    .job_i       (bk_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### tb/sv/tb_keyboard_controller_8042.sv
module tb_keyboard_controller_8042;
  timeunit 1ns;
  timeprecision 1ps;

  import kbc8042_pkg::*;

  localparam int unsigned CLK_PERIOD  = 10;
  // Cycles without any accepted beat on any channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // The pipeline latency plus a little margin.
  localparam int unsigned SETTLE_CYCLES = 4;

  // Command bytes the package does not name: the top of the pulse range and two
  // bytes that the controller does not decode.
  localparam logic [7:0] CMD_PULSE_ALL = 8'hFF;
  localparam logic [7:0] CMD_NONE      = 8'h00;
  localparam logic [7:0] CMD_UNUSED    = 8'h77;
  localparam logic [7:0] SET_QUERY     = 8'h00;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [7:0] cfg_data_i = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  kbc_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  kbc_out_t out_data_o;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  keyboard_controller_8042 DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Results predicted for accepted access beats, oldest first.
  kbc_out_t bus_results[$];
  int unsigned failures      = 0;
  int unsigned accesses_sent = 0;

  // When set, neither side inserts gaps.
  bit          no_idle       = 1'b0;
  // A request to the result side to hold ready low for this many cycles.
  int unsigned sink_hold_req = 0;

  // ---------------------------------------------------------------------------
  // Controller state as the testbench sees it.
  // ---------------------------------------------------------------------------
  logic [7:0]  obuf_q [FIFO_DEPTH];
  int unsigned obuf_cnt;
  int unsigned obuf_head;
  logic [7:0]  last_read_byte;
  logic [7:0]  status_m;
  logic [7:0]  config_m;
  logic [7:0]  outport_m;
  logic [7:0]  pend_ctrl_m;
  logic [7:0]  pend_kbd_m;
  logic [7:0]  inport_m;

  function automatic void reset_controller_state();
    foreach (obuf_q[i]) obuf_q[i] = '0;
    obuf_cnt       = 0;
    obuf_head      = 0;
    last_read_byte = '0;
    status_m       = STATUS_RESET;
    config_m       = CONFIG_RESET;
    outport_m      = OUTPORT_RESET;
    pend_ctrl_m    = '0;
    pend_kbd_m     = '0;
    inport_m       = '0;
  endfunction

  // The output-buffer-full status bit and its copy in the output port.
  function automatic void mark_output_full(input bit full);
    status_m[ST_OBF]   = full;
    outport_m[OUTP_OBF] = full;
  endfunction

  // Appends len bytes taken from the low end of bytes. The append is all or
  // nothing, and it fails once the count would reach the depth.
  function automatic bit queue_reply(input logic [31:0] bytes, input int unsigned len);
    int unsigned i;
    if (len == 0) return 1'b1;
    if (obuf_cnt + len >= FIFO_DEPTH) return 1'b0;
    for (i = 0; i < len; i++)
      obuf_q[(obuf_head + obuf_cnt + i) % FIFO_DEPTH] = bytes[8*i +: 8];
    obuf_cnt += len;
    mark_output_full(1'b1);
    return 1'b1;
  endfunction

  // Controller and keyboard replies are simply lost when there is no room.
  function automatic void reply_byte(input logic [7:0] b);
    void'(queue_reply({24'h0, b}, 1));
  endfunction

  function automatic void run_ctrl_cmd(input bit has_param, input logic [7:0] param,
                                       inout kbc_out_t r);
    case (pend_ctrl_m)
      CMD_READ_CFG: reply_byte(config_m);
      CMD_WRITE_CFG: begin
        // Wait for the parameter beat with the command still pending.
        if (!has_param) return;
        config_m = param;
      end
      CMD_VERSION: reply_byte(RPL_VERSION);
      CMD_SELF_TEST: begin
        status_m[ST_SYS] = 1'b1;
        reply_byte(RPL_TEST_OK);
      end
      CMD_IF_TEST, CMD_ZERO_B4, CMD_ZERO_C9: reply_byte(RPL_ZERO);
      CMD_KBD_OFF: begin
        config_m[CFG_KBD_INT] = 1'b0;
        r.irq_lower = 1'b1;
      end
      CMD_KBD_ON: begin
        config_m[CFG_KBD_INT] = 1'b1;
        if (obuf_cnt > 0) r.irq_raise = 1'b1;
      end
      CMD_READ_IN:  reply_byte(inport_m);
      CMD_READ_OUT: reply_byte(outport_m);
      CMD_WRITE_OUT: begin
        if (!has_param) return;
        outport_m          = param;
        r.port_write_valid = 1'b1;
        r.port_write_value = outport_m;
      end
      default: begin
        if (pend_ctrl_m >= CMD_PULSE_LOW) begin
          r.pulse_valid = 1'b1;
          r.pulse_value = outport_m ^ {4'h0, pend_ctrl_m[3:0]};
        end
      end
    endcase
    pend_ctrl_m = '0;
  endfunction

  function automatic void run_kbd_cmd(input logic [7:0] value);
    logic [7:0] cmd;
    bit         has_param;
    has_param = (pend_kbd_m != '0);
    cmd       = has_param ? pend_kbd_m : value;
    case (cmd)
      KCMD_SET: begin
        reply_byte(RPL_ACK);
        if (!has_param) begin
          pend_kbd_m = cmd;
          return;
        end
        if (value == SET_QUERY) reply_byte(RPL_SET_NUM);
      end
      KCMD_ENABLE, KCMD_DISABLE: reply_byte(RPL_ACK);
      KCMD_RESET: begin
        reply_byte(RPL_ACK);
        reply_byte(RPL_BAT_OK);
      end
      default: ;
    endcase
    pend_kbd_m = '0;
  endfunction

  // Applies one access to the controller state and returns the result beat it causes.
  function automatic kbc_out_t apply_access(input kbc_in_t a);
    kbc_out_t    r;
    int unsigned len;
    r = '0;
    case (a.op)
      OP_DATA_READ: begin
        if (obuf_cnt == 0) begin
          // Reading an empty buffer repeats the byte popped last.
          r.read_data = last_read_byte;
        end else begin
          last_read_byte = obuf_q[obuf_head];
          r.read_data    = last_read_byte;
          obuf_head      = (obuf_head + 1) % FIFO_DEPTH;
          obuf_cnt--;
          mark_output_full(obuf_cnt != 0);
          if (obuf_cnt > 0) r.irq_raise = 1'b1;
        end
      end
      OP_DATA_WRITE: begin
        status_m[ST_IBF] = 1'b1;
        if (pend_ctrl_m != '0) run_ctrl_cmd(1'b1, a.data_byte, r);
        else run_kbd_cmd(a.data_byte);
        status_m[ST_CMD] = 1'b0;
      end
      OP_STATUS_READ: begin
        r.read_data      = status_m;
        status_m[ST_IBF] = 1'b0;
      end
      OP_CMD_WRITE: begin
        status_m[ST_IBF] = 1'b1;
        pend_ctrl_m      = a.data_byte;
        status_m[ST_CMD] = 1'b1;
        run_ctrl_cmd(1'b0, '0, r);
      end
      OP_KEY: begin
        // Counts above four are clipped; an empty event still raises the interrupt when it is enabled.
        len = (a.key_count > KEY_MAX) ? KEY_MAX : a.key_count;
        if (!queue_reply(a.key_bytes, len)) r.key_dropped = 1'b1;
        else if (config_m[CFG_KBD_INT]) r.irq_raise = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_idle();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // A bus access. The key fields are noise for every op but the key event.
  function automatic kbc_in_t bus_access(input logic [2:0] op, input logic [7:0] data);
    kbc_in_t a;
    a.op        = op;
    a.data_byte = data;
    a.key_bytes = $urandom;
    a.key_count = 3'($urandom);
    return a;
  endfunction

  function automatic kbc_in_t key_event(input logic [31:0] bytes, input logic [2:0] count);
    kbc_in_t a;
    a.op        = OP_KEY;
    a.data_byte = 8'($urandom);
    a.key_bytes = bytes;
    a.key_count = count;
    return a;
  endfunction

  // Sends one access beat and records the result it must produce. Valid is only
  // lowered when a gap follows, so back-to-back beats keep it high throughout.
  task automatic send_access(input kbc_in_t item);
    int unsigned gap;
    bit          taken;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    bus_results.push_back(apply_access(item));
    if (item.op <= OP_KEY) accesses_sent++;
  endtask

  // Stops offering beats until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (bus_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The input port value may only change while the block is idle.
  task automatic write_input_port(input logic [7:0] value);
    bit taken;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    inport_m = value;
  endtask

  // Reads everything buffered and then once more from the empty buffer.
  task automatic drain_buffer();
    int unsigned n;
    int unsigned i;
    n = obuf_cnt + 1;
    for (i = 0; i < n; i++) send_access(bus_access(OP_DATA_READ, 8'($urandom)));
  endtask

  function automatic logic [7:0] pick_ctrl_cmd();
    case ($urandom_range(0, 16))
      0:  return CMD_READ_CFG;
      1:  return CMD_WRITE_CFG;
      2:  return CMD_VERSION;
      3:  return CMD_SELF_TEST;
      4:  return CMD_IF_TEST;
      5:  return CMD_ZERO_B4;
      6:  return CMD_ZERO_C9;
      7:  return CMD_KBD_OFF;
      8:  return CMD_KBD_ON;
      9:  return CMD_READ_IN;
      10: return CMD_READ_OUT;
      11: return CMD_WRITE_OUT;
      12: return CMD_WRITE_OUT;
      13: return CMD_PULSE_LOW + 8'($urandom_range(0, 14));
      14: return CMD_KBD_ON;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_key_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 92) return 3'($urandom_range(1, KEY_MAX));
    return 3'($urandom_range(KEY_MAX + 1, 7));
  endfunction

  // A controller command, with its parameter beat when it takes one.
  task automatic controller_sequence();
    logic [7:0] cmd;
    cmd = pick_ctrl_cmd();
    send_access(bus_access(OP_CMD_WRITE, cmd));
    if (cmd == CMD_WRITE_CFG || cmd == CMD_WRITE_OUT)
      send_access(bus_access(OP_DATA_WRITE, 8'($urandom)));
    if (obuf_cnt > 0 && $urandom_range(0, 1) == 1)
      send_access(bus_access(OP_DATA_READ, 8'($urandom)));
  endtask

  // A keyboard command; the scan code set command takes a second byte.
  task automatic keyboard_sequence();
    case ($urandom_range(0, 5))
      0, 1: begin
        send_access(bus_access(OP_DATA_WRITE, KCMD_SET));
        send_access(bus_access(OP_DATA_WRITE,
                               ($urandom_range(0, 2) == 0) ? SET_QUERY : 8'($urandom)));
      end
      2: send_access(bus_access(OP_DATA_WRITE, KCMD_ENABLE));
      3: send_access(bus_access(OP_DATA_WRITE, KCMD_DISABLE));
      4: send_access(bus_access(OP_DATA_WRITE, KCMD_RESET));
      default: send_access(bus_access(OP_DATA_WRITE, 8'($urandom)));
    endcase
  endtask

  // Two-beat sequences interrupted by other traffic before the second beat.
  task automatic broken_sequence();
    logic [7:0] cmd;
    cmd = ($urandom_range(0, 1) == 1) ? CMD_WRITE_CFG : CMD_WRITE_OUT;
    case ($urandom_range(0, 2))
      0: begin
        send_access(bus_access(OP_CMD_WRITE, cmd));
        if ($urandom_range(0, 1) == 1) send_access(bus_access(OP_STATUS_READ, 8'($urandom)));
        else send_access(key_event($urandom, pick_key_count()));
        send_access(bus_access(OP_DATA_WRITE, 8'($urandom)));
      end
      1: begin
        send_access(bus_access(OP_DATA_WRITE, KCMD_SET));
        send_access(bus_access(OP_CMD_WRITE, pick_ctrl_cmd()));
        send_access(bus_access(OP_DATA_WRITE, 8'($urandom)));
      end
      default: begin
        send_access(bus_access(OP_CMD_WRITE, cmd));
        send_access(bus_access(OP_CMD_WRITE, pick_ctrl_cmd()));
      end
    endcase
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned goal;
    int unsigned roll;
    int unsigned n;
    int unsigned i;
    goal = accesses_sent + count;
    while (accesses_sent < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
        send_access(bus_access(OP_DATA_READ, 8'($urandom)));
      end else if (roll < 32) begin
        // Empty the buffer now and then so that commands find room again.
        n = obuf_cnt + $urandom_range(0, 1);
        for (i = 0; i < n; i++) send_access(bus_access(OP_DATA_READ, 8'($urandom)));
      end else if (roll < 40) begin
        send_access(bus_access(OP_STATUS_READ, 8'($urandom)));
      end else if (roll < 56) begin
        send_access(key_event($urandom, pick_key_count()));
      end else if (roll < 72) begin
        controller_sequence();
      end else if (roll < 86) begin
        keyboard_sequence();
      end else if (roll < 95) begin
        broken_sequence();
      end else begin
        // Undefined ops: the block must answer with an all-zero beat.
        send_access(bus_access(3'($urandom_range(OP_KEY + 1, 7)), 8'($urandom)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Status and data port straight out of reset, and the output port reset value.
  task automatic test_reset_values();
    send_access(bus_access(OP_STATUS_READ, '0));
    send_access(bus_access(OP_DATA_READ, '1));
    send_access(bus_access(OP_CMD_WRITE, CMD_READ_OUT));
    send_access(bus_access(OP_STATUS_READ, '1));
    send_access(bus_access(OP_DATA_READ, '0));
  endtask

  // The read input port command returns whatever was last written to the register.
  task automatic test_input_port();
    write_input_port('1);
    send_access(bus_access(OP_CMD_WRITE, CMD_READ_IN));
    send_access(bus_access(OP_DATA_READ, '0));
    write_input_port('0);
    send_access(bus_access(OP_CMD_WRITE, CMD_READ_IN));
    send_access(bus_access(OP_DATA_READ, '0));
  endtask

  task automatic test_controller_commands();
    send_access(bus_access(OP_CMD_WRITE, CMD_READ_CFG));
    send_access(bus_access(OP_CMD_WRITE, CMD_VERSION));
    send_access(bus_access(OP_CMD_WRITE, CMD_SELF_TEST));
    send_access(bus_access(OP_CMD_WRITE, CMD_IF_TEST));
    send_access(bus_access(OP_CMD_WRITE, CMD_ZERO_B4));
    send_access(bus_access(OP_CMD_WRITE, CMD_ZERO_C9));
    send_access(bus_access(OP_CMD_WRITE, CMD_READ_OUT));
    send_access(bus_access(OP_STATUS_READ, '0));
    drain_buffer();
    // Clear the configuration byte, read it back, drive the output port, then pulse it and send undecoded commands.
    send_access(bus_access(OP_CMD_WRITE, CMD_WRITE_CFG));
    send_access(bus_access(OP_DATA_WRITE, '0));
    send_access(bus_access(OP_CMD_WRITE, CMD_READ_CFG));
    send_access(bus_access(OP_CMD_WRITE, CMD_WRITE_OUT));
    send_access(bus_access(OP_DATA_WRITE, '1));
    send_access(bus_access(OP_CMD_WRITE, CMD_PULSE_LOW));
    send_access(bus_access(OP_CMD_WRITE, CMD_PULSE_ALL));
    send_access(bus_access(OP_CMD_WRITE, CMD_NONE));
    send_access(bus_access(OP_CMD_WRITE, CMD_UNUSED));
    // Enabling with a byte buffered raises the interrupt; disabling lowers it.
    send_access(bus_access(OP_CMD_WRITE, CMD_KBD_ON));
    send_access(bus_access(OP_CMD_WRITE, CMD_KBD_OFF));
    send_access(key_event(32'h0000_1C9C, 3'd2));
    send_access(bus_access(OP_CMD_WRITE, CMD_WRITE_CFG));
    send_access(bus_access(OP_DATA_WRITE, CONFIG_RESET));
    drain_buffer();
  endtask

  task automatic test_keyboard_commands();
    send_access(bus_access(OP_DATA_WRITE, KCMD_SET));
    send_access(bus_access(OP_DATA_WRITE, SET_QUERY));
    send_access(bus_access(OP_DATA_WRITE, KCMD_SET));
    send_access(bus_access(OP_DATA_WRITE, 8'h03));
    send_access(bus_access(OP_DATA_WRITE, KCMD_ENABLE));
    send_access(bus_access(OP_DATA_WRITE, KCMD_DISABLE));
    send_access(bus_access(OP_DATA_WRITE, KCMD_RESET));
    send_access(bus_access(OP_DATA_WRITE, 8'h12));
    drain_buffer();
  endtask

  // Key events of several lengths, clipped ones among them, up to the point where the buffer refuses them.
  task automatic test_key_events();
    send_access(key_event('0, 3'd0));
    send_access(key_event('1, 3'd7));
    send_access(key_event('0, 3'd4));
    send_access(key_event(32'h8040_2010, 3'd4));
    send_access(key_event(32'h00FF_00FF, 3'd3));
    // Fifteen bytes are buffered now, so this one is dropped and so is the reply.
    send_access(key_event('1, 3'd1));
    send_access(bus_access(OP_CMD_WRITE, CMD_VERSION));
    send_access(key_event('0, 3'd5));
    drain_buffer();
  endtask

  task automatic test_unknown_ops();
    send_access(bus_access(3'd5, '1));
    send_access(bus_access(3'd6, '1));
    send_access(bus_access(3'd7, '0));
  endtask

  // The result side holds off while beats keep coming, so the block has to
  // stall its input.
  task automatic test_backpressure();
    int unsigned i;
    wait_drained();
    sink_hold_req = 120;
    no_idle       = 1'b1;
    for (i = 0; i < 16; i++) begin
      if (i % 3 == 0) send_access(bus_access(OP_DATA_READ, 8'($urandom)));
      else send_access(key_event($urandom, 3'($urandom_range(1, 2))));
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Random traffic under several input port settings, one phase without gaps.
  task automatic test_random_phases();
    write_input_port('1);
    random_traffic(200);
    write_input_port('0);
    random_traffic(200);
    write_input_port(8'hA5);
    no_idle = 1'b1;
    random_traffic(160);
    no_idle = 1'b0;
    write_input_port(8'($urandom));
    random_traffic(200);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, with a long hold whenever one is requested.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned span;
    bit          level;
    wait (rst_ni);
    forever begin
      if (sink_hold_req != 0) begin
        level         = 1'b0;
        span          = sink_hold_req;
        sink_hold_req = 0;
      end else if (no_idle) begin
        level = 1'b1;
        span  = 1;
      end else begin
        span  = pick_idle();
        level = (span == 0);
        if (level) span = $urandom_range(1, 8);
      end
      out_ready_i <= level;
      repeat (span) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      failures++;
    end
  endtask

  task automatic check_flag(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      failures++;
    end
  endtask

  // Handshakes are sampled at the falling edge, where everything driven at the
  // rising edge has settled; a beat seen there is taken at the next rising edge.
  initial begin : result_checker
    kbc_out_t want;
    kbc_out_t got;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (bus_results.size() == 0) begin
          $error("result beat with no access waiting for it");
          failures++;
        end else begin
          want = bus_results.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_flag("irq_raise", want.irq_raise, got.irq_raise);
          check_flag("irq_lower", want.irq_lower, got.irq_lower);
          check_flag("port_write_valid", want.port_write_valid, got.port_write_valid);
          check_field("port_write_value", want.port_write_value, got.port_write_value);
          check_flag("pulse_valid", want.pulse_valid, got.pulse_valid);
          check_field("pulse_value", want.pulse_value, got.pulse_value);
          check_flag("key_dropped", want.key_dropped, got.key_dropped);
        end
      end
    end
  end

  // Ends a hung run: too many cycles in a row without any beat on any channel.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("keyboard_controller_8042 test failed");
        $finish;
      end
    end
  end

  initial begin
    reset_controller_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_input_port();
    test_controller_commands();
    test_keyboard_commands();
    test_key_events();
    test_unknown_ops();
    test_backpressure();
    test_random_phases();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bus_results.size() != 0) begin
      $error("%0d results never arrived", bus_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("keyboard_controller_8042 test passed");
    end else begin
      $display("keyboard_controller_8042 test failed");
    end
    $finish;
  end

endmodule
